// ----- sv/rbdpd_pkg.sv -----
// Package for the block-delta raw pixel decoder.
// Holds the controller-to-datapath command type and the fixed decode constants.
// No dependencies.
package rbdpd_pkg;

   localparam int unsigned BLOCK_BITS = 128;

   // Pixels per block in the two sample modes.
   localparam logic [3:0] NPIX_NARROW = 4'd14;
   localparam logic [3:0] NPIX_WIDE   = 4'd11;

   // Field widths, read from the top of the block downward.
   localparam logic [6:0] SEED_BITS_NARROW  = 7'd12;
   localparam logic [6:0] SEED_BITS_WIDE    = 7'd14;
   localparam logic [6:0] DELTA_BITS_NARROW = 7'd8;
   localparam logic [6:0] DELTA_BITS_WIDE   = 7'd10;
   localparam logic [6:0] CODE_BITS         = 7'd2;

   localparam logic [15:0] ZERO_BASE_NARROW = 16'h0080;
   localparam logic [15:0] ZERO_BASE_WIDE   = 16'h0200;
   localparam logic [15:0] BASE_CMP_NARROW  = 16'h0800;
   localparam logic [15:0] BASE_CMP_WIDE    = 16'h2000;
   localparam logic [15:0] BLACK_LEVEL      = 16'h000F;
   localparam logic [15:0] FIELD_MAX        = 16'h3FFF;
   localparam logic [13:0] CLIP_NARROW      = 14'h0FFF;

   localparam logic [1:0] CODE_FOUR = 2'd3;

   typedef struct packed {
      logic       load;        // capture a new block and clear the lanes
      logic       step;        // decode one pixel this cycle
      logic       wide;        // 14-bit sample mode
      logic       seed_phase;  // pixel reads a full-width seed field
      logic       code_phase;  // pixel is preceded by a shift code
      logic       lane;        // odd or even pixel lane
      logic [3:0] index;       // pixel position in the block
      logic       last;        // final pixel of the block
   } cmd_type;

endpackage

// ----- sv/rbdpd_ctrl.sv -----
// Controller for the block-delta raw pixel decoder.
// Holds the sample mode register and sequences the pixels of a block.
// Depends on rbdpd_pkg.
module rbdpd_ctrl import rbdpd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  logic    csr_we,
   input  logic    csr_wdata,
   output cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic       state_ff, state_in;
   logic [3:0] pix_ff, pix_in;
   logic [1:0] mod3_ff, mod3_in;
   logic       mode_ff, mode_in;
   logic       last_step;
   logic       accept;
   logic [3:0] npix;

   assign npix      = mode_ff ? NPIX_WIDE : NPIX_NARROW;
   assign last_step = (state_ff == ST_RUN) && (pix_ff == npix - 4'd1);
   // A new block may be taken on the cycle that decodes the previous last pixel.
   assign busy      = (state_ff == ST_RUN) && !last_step;
   assign accept    = start && !busy;

   always_comb begin
      state_in = state_ff;
      pix_in   = pix_ff;
      mod3_in  = mod3_ff;
      mode_in  = csr_we ? csr_wdata : mode_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               pix_in   = 4'd0;
               mod3_in  = 2'd0;
            end
         end
         ST_RUN: begin
            pix_in  = pix_ff + 4'd1;
            mod3_in = (mod3_ff == 2'd2) ? 2'd0 : mod3_ff + 2'd1;
            if (last_step) begin
               if (accept) begin
                  pix_in  = 4'd0;
                  mod3_in = 2'd0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pix_ff   <= 4'd0;
         mod3_ff  <= 2'd0;
         mode_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pix_ff   <= pix_in;
         mod3_ff  <= mod3_in;
         mode_ff  <= mode_in;
      end
   end

   always_comb begin
      cmd.load       = accept;
      cmd.step       = (state_ff == ST_RUN);
      cmd.wide       = mode_ff;
      cmd.seed_phase = (pix_ff < 4'd2);
      cmd.code_phase = (mod3_ff == 2'd2);
      cmd.lane       = pix_ff[0];
      cmd.index      = pix_ff;
      cmd.last       = last_step;
   end

endmodule

// ----- sv/rbdpd_dpath.sv -----
// Datapath for the block-delta raw pixel decoder.
// Unpacks fields from the block register, runs the two lanes and clamps.
// Depends on rbdpd_pkg.
module rbdpd_dpath import rbdpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [63:0] req_block_low,
   input  logic [63:0] req_block_high,
   output logic        rsp_valid,
   output logic [13:0] rsp_pixel_value,
   output logic [3:0]  rsp_pixel_index,
   output logic        rsp_last_pixel
);

   logic [BLOCK_BITS-1:0] bits_ff, bits_in;
   logic [1:0]            seeded_ff, seeded_in;
   logic [15:0]           last_ff [2];
   logic [15:0]           last_in;
   logic [2:0]            shift_ff, shift_cur;
   logic                  valid_ff;
   logic [13:0]           value_ff, value_in;
   logic [3:0]            index_ff;
   logic                  lastpix_ff;

   logic [13:0] raw;
   logic [1:0]  code;
   logic [6:0]  consume;
   logic [15:0] scaled, base, zero_base, base_cmp, lane_last, carry, sum, v, diff;
   logic        seeded;

   // Fields are taken from the top of the block; the register shifts left.
   always_comb begin
      code = bits_ff[127:126];
      if (cmd.seed_phase) begin
         raw     = cmd.wide ? bits_ff[127:114] : {2'b00, bits_ff[127:116]};
         consume = cmd.wide ? SEED_BITS_WIDE : SEED_BITS_NARROW;
      end else if (cmd.code_phase) begin
         raw     = cmd.wide ? {4'd0, bits_ff[125:116]} : {6'd0, bits_ff[125:118]};
         consume = CODE_BITS + (cmd.wide ? DELTA_BITS_WIDE : DELTA_BITS_NARROW);
      end else begin
         raw     = cmd.wide ? {4'd0, bits_ff[127:118]} : {6'd0, bits_ff[127:120]};
         consume = cmd.wide ? DELTA_BITS_WIDE : DELTA_BITS_NARROW;
      end
   end

   always_comb begin
      if (cmd.code_phase) begin
         shift_cur = (code == CODE_FOUR) ? 3'd4 : {1'b0, code};
      end else begin
         shift_cur = shift_ff;
      end
      zero_base = cmd.wide ? ZERO_BASE_WIDE : ZERO_BASE_NARROW;
      base_cmp  = cmd.wide ? BASE_CMP_WIDE : BASE_CMP_NARROW;
      base      = zero_base << shift_cur;
      scaled    = {2'b00, raw} << shift_cur;
      lane_last = last_ff[cmd.lane];
      seeded    = seeded_ff[cmd.lane];
      // Carry-over from the lane's last value only while the base is small.
      carry     = ((base < base_cmp) && (lane_last > base)) ? lane_last - base : 16'd0;
      sum       = scaled + carry;
      // An unseeded lane passes the raw field; a zero leaves the lane unseeded.
      v         = seeded ? sum : {2'b00, raw};
      last_in   = v;
      diff      = v - BLACK_LEVEL;
      if (v < BLACK_LEVEL) begin
         value_in = 14'd0;
      end else if (!cmd.wide && (diff > FIELD_MAX)) begin
         value_in = CLIP_NARROW;
      end else begin
         value_in = diff[13:0];
      end
   end

   always_comb begin
      bits_in   = bits_ff;
      seeded_in = seeded_ff;
      if (cmd.step) begin
         bits_in = bits_ff << consume;
         if (!seeded && (raw != 14'd0)) begin
            seeded_in[cmd.lane] = 1'b1;
         end
      end
      if (cmd.load) begin
         bits_in   = {req_block_high, req_block_low};
         seeded_in = 2'b00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= 2'b00;
         valid_ff  <= 1'b0;
      end else begin
         seeded_ff <= seeded_in;
         valid_ff  <= cmd.step;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      if (cmd.step) begin
         last_ff[cmd.lane] <= last_in;
         shift_ff          <= shift_cur;
         value_ff          <= value_in;
         index_ff          <= cmd.index;
         lastpix_ff        <= cmd.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pixel_value = value_ff;
   assign rsp_pixel_index = index_ff;
   assign rsp_last_pixel  = valid_ff && lastpix_ff;

endmodule

// ----- sv/raw_block_delta_pixel_decoder_core.sv -----
// Block-delta raw pixel decoder, top level.
// Once start is taken the controller enters its run state and the first pixel word is then registered.
// Throughput: one pixel word per cycle while a block is decoding, 14 pixels per block in 12-bit mode
// and 11 in 14-bit mode; the next block is taken on the last pixel cycle.
// Reset is synchronous and active high; it clears the controller, lane flags and sample mode.
// The receiver cannot stall; each word is valid for exactly one cycle.
module raw_block_delta_pixel_decoder_core import rbdpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_block_low,
   input  logic [63:0] req_block_high,
   input  logic        csr_we,
   input  logic        csr_wdata,
   output logic        rsp_valid,
   output logic [13:0] rsp_pixel_value,
   output logic [3:0]  rsp_pixel_index,
   output logic        rsp_last_pixel
);

   cmd_type cmd;

   rbdpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd)
   );

   rbdpd_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_block_low   (req_block_low),
      .req_block_high  (req_block_high),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_last_pixel  (rsp_last_pixel)
   );

`ifndef SYNTHESIS
   // A word only follows a decode step.
   a_word_after_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.step))
      else $error("result word without a decode step");

   // Words of one block come out back to back.
   a_words_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_pixel) |=> rsp_valid)
      else $error("gap inside a block");

   // A taken block starts at pixel zero.
   a_first_index: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 (rsp_valid && (rsp_pixel_index == 4'd0)))
      else $error("block did not start at pixel zero");

   // The last pixel carries the mode's final index.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_last_pixel |-> ((rsp_pixel_index == NPIX_NARROW - 4'd1) ||
                          (rsp_pixel_index == NPIX_WIDE - 4'd1)))
      else $error("last pixel at wrong index");
`endif

endmodule

// ----- sim/raw_block_delta_pixel_decoder_core_tb.sv -----
// Self-checking testbench for the block-delta raw pixel decoder core.
// Predicts every pixel word of each accepted block in a small scoreboard class and compares.
// Depends on rbdpd_pkg and raw_block_delta_pixel_decoder_core.
`timescale 1ns / 100ps

module raw_block_delta_pixel_decoder_core_tb;
   import rbdpd_pkg::*;

   localparam bit MODE_NARROW = 1'b0;
   localparam bit MODE_WIDE   = 1'b1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PHASE_ITEMS = 60;

   typedef struct {
      logic [13:0] value;
      logic [3:0]  position;
      logic        is_last;
   } pixel_word_type;

   typedef int unsigned field_list_type[18];

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_block_low;
   logic [63:0] req_block_high;
   logic        csr_we;
   logic        csr_wdata;
   logic        rsp_valid;
   logic [13:0] rsp_pixel_value;
   logic [3:0]  rsp_pixel_index;
   logic        rsp_last_pixel;
   int          cycle_count = 0;

   class pixel_scoreboard;
      pixel_word_type expected_q[$];
      bit wide = MODE_NARROW;
      int errors = 0;
      int words_checked = 0;
      int blocks_narrow = 0;
      int blocks_wide = 0;

      function int unsigned slice(logic [127:0] blk, int lsb, int w);
         logic [127:0] shifted;
         shifted = blk >> lsb;
         return int'(shifted[15:0]) & ((1 << w) - 1);
      endfunction

      // Decodes one block the way the core should and queues its pixel words.
      function void note_block(logic [63:0] lo, logic [63:0] hi);
         logic [127:0] blk;
         int top, npix, seed_w, delta_w, k, lane;
         int unsigned zbase, base_cmp, mul, base, b, v, res;
         int unsigned last_val[2];
         bit seeded[2];
         pixel_word_type word;
         blk = {hi, lo};
         top = 128;
         npix = wide ? int'(NPIX_WIDE) : int'(NPIX_NARROW);
         seed_w = wide ? int'(SEED_BITS_WIDE) : int'(SEED_BITS_NARROW);
         delta_w = wide ? int'(DELTA_BITS_WIDE) : int'(DELTA_BITS_NARROW);
         zbase = wide ? ZERO_BASE_WIDE : ZERO_BASE_NARROW;
         base_cmp = wide ? BASE_CMP_WIDE : BASE_CMP_NARROW;
         mul = 0;
         base = 0;
         last_val = '{0, 0};
         seeded = '{0, 0};
         if (wide) blocks_wide++;
         else blocks_narrow++;
         // Fields are consumed from the top of the 128-bit string downward.
         for (k = 0; k < npix; k++) begin
            lane = k % 2;
            if (k % 3 == 2) begin
               top -= int'(CODE_BITS);
               b = slice(blk, top, int'(CODE_BITS));
               if (b == CODE_FOUR) b = 4;
               base = zbase << b;
               mul = 1 << b;
            end
            top -= (k < 2) ? seed_w : delta_w;
            v = slice(blk, top, (k < 2) ? seed_w : delta_w);
            if (seeded[lane]) begin
               v = (v * mul) & 32'hFFFF;
               if (base < base_cmp && last_val[lane] > base)
                  v = (v + last_val[lane] - base) & 32'hFFFF;
               last_val[lane] = v;
            end else if (v != 0) begin
               seeded[lane] = 1'b1;
               last_val[lane] = v;
            end else begin
               v = last_val[lane];
            end
            if (v < BLACK_LEVEL) res = 0;
            else if (!wide && v - BLACK_LEVEL > FIELD_MAX) res = CLIP_NARROW;
            else res = (v - BLACK_LEVEL) & FIELD_MAX;
            word.value = res[13:0];
            word.position = k[3:0];
            word.is_last = (k == npix - 1);
            expected_q.push_back(word);
         end
      endfunction

      function void check_word(logic [13:0] value, logic [3:0] position, logic is_last);
         pixel_word_type want;
         if (expected_q.size() == 0) begin
            $error("pixel word %0h at index %0d arrived with nothing expected", value, position);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         words_checked++;
         if (value !== want.value) begin
            $error("pixel_value: expected %0h, actual %0h", want.value, value);
            errors++;
         end
         if (position !== want.position) begin
            $error("pixel_index: expected %0d, actual %0d", want.position, position);
            errors++;
         end
         if (is_last !== want.is_last) begin
            $error("last_pixel: expected %0b, actual %0b", want.is_last, is_last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   pixel_scoreboard sb;

   raw_block_delta_pixel_decoder_core DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_block_low   (req_block_low),
      .req_block_high  (req_block_high),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_word(rsp_pixel_value, rsp_pixel_index, rsp_last_pixel);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Width of the field at read position j; seeds come first, then a code before each triple.
   function automatic int field_width(bit wm, int j);
      if (j < 2) return wm ? int'(SEED_BITS_WIDE) : int'(SEED_BITS_NARROW);
      if ((j - 2) % 4 == 0) return int'(CODE_BITS);
      return wm ? int'(DELTA_BITS_WIDE) : int'(DELTA_BITS_NARROW);
   endfunction

   function automatic logic [127:0] pack_block(bit wm, field_list_type fields);
      logic [127:0] blk;
      int top, j, w;
      blk = '0;
      top = 128;
      for (j = 0; j < (wm ? 14 : 18); j++) begin
         w = field_width(wm, j);
         top -= w;
         blk |= 128'(fields[j] & ((1 << w) - 1)) << top;
      end
      return blk;
   endfunction

   function automatic logic [127:0] uniform_block(bit wm, int unsigned seed_a,
                                                  int unsigned seed_b, int unsigned code,
                                                  int unsigned delta);
      field_list_type fields;
      int j;
      fields[0] = seed_a;
      fields[1] = seed_b;
      for (j = 2; j < 18; j++)
         fields[j] = (field_width(wm, j) == int'(CODE_BITS)) ? code : delta;
      return pack_block(wm, fields);
   endfunction

   function automatic int unsigned pick_value();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 32'hFFFF;
         2: return $urandom_range(1, 20);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [127:0] random_block(bit wm);
      field_list_type fields;
      int j;
      if ($urandom_range(0, 9) < 3)
         return {$urandom, $urandom, $urandom, $urandom};
      for (j = 0; j < 18; j++) begin
         if (j < 2 && $urandom_range(0, 3) == 0) fields[j] = 0;
         else if (field_width(wm, j) == int'(CODE_BITS)) fields[j] = $urandom_range(0, 3);
         else fields[j] = pick_value();
      end
      return pack_block(wm, fields);
   endfunction

   // Holds start high with the new word; a zero gap keeps it high across blocks.
   task automatic send_block(logic [127:0] blk, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_block_low <= blk[63:0];
      req_block_high <= blk[127:64];
      do @(posedge clock); while (busy);
      sb.note_block(blk[63:0], blk[127:64]);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_mode(bit m);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      sb.wide = m;
      csr_we <= 1'b0;
   endtask

   task automatic run_directed();
      bit wm;
      int c;
      wm = sb.wide;
      send_block('0, $urandom_range(0, 19));
      send_block('1, $urandom_range(0, 19));
      for (c = 0; c < 4; c++)
         send_block(uniform_block(wm, 32'h120, 32'h7FF, c, 32'hFFFF), $urandom_range(0, 19));
      // Zero seeds: the first nonzero delta of each lane becomes its seed.
      send_block(uniform_block(wm, 0, 0, 1, 32'h33), $urandom_range(0, 19));
      // Lanes that never see a nonzero value keep putting out zero.
      send_block(uniform_block(wm, 0, 0, 2, 0), $urandom_range(0, 19));
      send_block(uniform_block(wm, 5, 3, 0, 1), $urandom_range(0, 19));
      send_block(uniform_block(wm, 32'hFFFF, 32'hFFFF, 3, 32'hFFFF), $urandom_range(0, 19));
      send_block(uniform_block(wm, 32'hFFFF, 32'hFFFF, 2, 32'hFFFF), 0);
      send_block({4{32'h5555_5555}}, 0);
   endtask

   task automatic run_random(int n);
      int i, gap;
      bit burst;
      burst = 1'b0;
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) burst = !burst;
         gap = burst ? 0 : $urandom_range(0, 19);
         if ($urandom_range(0, 39) == 0) drain();
         send_block(random_block(sb.wide), gap);
      end
   endtask

   initial begin
      bit phase_modes[6];
      int p;
      phase_modes = '{MODE_NARROW, MODE_WIDE, MODE_WIDE, MODE_NARROW, MODE_WIDE, MODE_NARROW};
      sb = new();
      reset <= 1'b1;
      start <= 1'b0;
      req_block_low <= '0;
      req_block_high <= '0;
      csr_we <= 1'b0;
      csr_wdata <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_mode(MODE_NARROW);
      run_directed();
      write_mode(MODE_WIDE);
      run_directed();
      for (p = 0; p < 6; p++) begin
         write_mode(phase_modes[p]);
         run_random(RANDOM_PHASE_ITEMS);
      end

      drain();
      repeat (4) @(posedge clock);
      $display("Decoded %0d blocks in 12-bit mode and %0d in 14-bit mode.",
               sb.blocks_narrow, sb.blocks_wide);
      $display("Checked %0d pixel words, mismatches found: %0d",
               sb.words_checked, sb.errors);
      if (sb.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/rbdpd_pkg.sv
sv/rbdpd_ctrl.sv
sv/rbdpd_dpath.sv
sv/raw_block_delta_pixel_decoder_core.sv
sim/raw_block_delta_pixel_decoder_core_tb.sv
